>>> sv/rk6_pkg.sv
package rk6_pkg;

  localparam int WORD_W     = 64;
  localparam int DIGIT_W    = 16;
  localparam int NUM_DIGITS = WORD_W / DIGIT_W;
  localparam int STAGES     = 8;
  localparam int STG_W      = $clog2(STAGES);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LAMBDA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 2'd2;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // tableau fractions, row-major a(s,j), then the b weights
  localparam int A_NUM [STAGES*STAGES] = '{
    0,   0,   0,   0,   0,   0,   0,  0,
    1,   0,   0,   0,   0,   0,   0,  0,
    1,   1,   0,   0,   0,   0,   0,  0,
    0,  -4,   5,   0,   0,   0,   0,  0,
    -1, -29,  31,   0,   0,   0,   0,  0,
    3,   8,  -4,   1,  14,   0,   0,  0,
    -17, -5,   1,   1, -13,  11,   0,  0,
    20,  12, -31,  -1,  34, -11,  16,  0
  };
  localparam int A_DEN [STAGES*STAGES] = '{
    1,  1,  1,  1,  1,  1,  1,  1,
    6,  1,  1,  1,  1,  1,  1,  1,
    12, 12,  1,  1,  1,  1,  1,  1,
    1, 33, 11,  1,  1,  1,  1,  1,
    4, 44, 22,  1,  1,  1,  1,  1,
    11, 33, 11, 11, 33,  1,  1,  1,
    48, 12,  1,  1, 12, 16,  1,  1,
    39, 39, 39, 39, 39, 39, 39,  1
  };
  localparam int B_NUM [STAGES] = '{13, 0, 4, 11, 0, 11, 4, 13};
  localparam int B_DEN [STAGES] = '{200, 1, 25, 40, 1, 40, 25, 200};

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              sat;
  } mul_res_t;

  // fraction to signed fixed point, rounded to nearest, by restoring division
  function automatic logic [WORD_W-1:0] frac_to_fixed(int num, int den, int frac_bits);
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] ip;
    logic [WORD_W-1:0] fr;
    logic [WORD_W-1:0] mag;
    n   = (num < 0) ? WORD_W'(-num) : WORD_W'(num);
    d   = WORD_W'(den);
    rem = n;
    ip  = '0;
    fr  = '0;
    for (int i = 0; i < 32; i++) begin
      if (rem >= d) begin
        rem = rem - d;
        ip  = ip + WORD_W'(1);
      end
    end
    for (int i = 0; i < frac_bits; i++) begin
      rem = rem << 1;
      fr  = fr << 1;
      if (rem >= d) begin
        rem   = rem - d;
        fr[0] = 1'b1;
      end
    end
    mag = (ip << frac_bits) + fr;
    if ((rem << 1) >= d) begin
      mag = mag + WORD_W'(1);
    end
    return (num < 0) ? (~mag + WORD_W'(1)) : mag;
  endfunction

endpackage

>>> sv/rk6_mul.sv
module rk6_mul #(
  parameter int FRAC_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rk6_pkg::WORD_W-1:0] x_i,
  input  logic [rk6_pkg::WORD_W-1:0] y_i,
  output logic                       done_o,
  output rk6_pkg::mul_res_t          res_o
);

  localparam int W   = rk6_pkg::WORD_W;
  localparam int DW  = rk6_pkg::DIGIT_W;
  localparam int ND  = rk6_pkg::NUM_DIGITS;
  localparam int CW  = $clog2(ND);
  localparam logic [W-1:0] ROUND = W'(1) << (FRAC_BITS - 1);

  logic [W-1:0]      ma_q;
  logic [W-1:0]      mb_q;
  logic [W-1:0]      upper_q;
  logic [W-1:0]      low_q;
  logic              neg_q;
  logic [CW-1:0]     cnt_q;
  logic              run_q;
  logic              fin_q;
  logic              done_q;
  rk6_pkg::mul_res_t res_q;

  logic [W+DW-1:0]   partial;
  logic [2*W-1:0]    full;
  logic [W-1:0]      mag;
  logic              over;
  logic [W-1:0]      x_abs;
  logic [W-1:0]      y_abs;

  assign x_abs = x_i[W-1] ? (~x_i + W'(1)) : x_i;
  assign y_abs = y_i[W-1] ? (~y_i + W'(1)) : y_i;

  // one 16-bit digit of the multiplier per cycle, low part shifts out
  assign partial = (W+DW)'(ma_q) * (W+DW)'(mb_q[DW-1:0]) + (W+DW)'(upper_q);

  assign full = {upper_q, low_q};
  assign mag  = full[FRAC_BITS+W-1:FRAC_BITS];
  assign over = (|full[2*W-1:FRAC_BITS+W]) ||
                (mag[W-1] && (!neg_q || (|mag[W-2:0])));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(ND - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q    <= x_abs;
      mb_q    <= y_abs;
      neg_q   <= x_i[W-1] ^ y_i[W-1];
      upper_q <= ROUND;
    end else if (run_q) begin
      upper_q <= partial[W+DW-1:DW];
      low_q   <= {partial[DW-1:0], low_q[W-1:DW]};
      mb_q    <= mb_q >> DW;
    end
    if (fin_q) begin
      res_q.sat <= over;
      if (over) begin
        res_q.value <= neg_q ? rk6_pkg::SAT_MIN : rk6_pkg::SAT_MAX;
      end else begin
        res_q.value <= neg_q ? (~mag + W'(1)) : mag;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/rk6_linear_ode_step_unit.sv
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    restart_i
// out       output     out_valid_o / out_stall_i  z_value_o, saturated_o
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// a restart item is taken in the idle state and loads its result directly; a step item runs
// from its accept through 53 products (issue, four 16-bit digits, round, done, update) on one
// shared multiplier, then a finish state that waits until the output register is free.
// reset loads the register defaults and z = initial value, no clearing pass.
// a stalled output holds the next item back; the input is taken only
// when the block is idle and the output register is free or being taken.
module rk6_linear_ode_step_unit #(
  parameter int FRAC_BITS = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rk6_pkg::WORD_W-1:0]    z_value_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_we_i,
  input  logic [rk6_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rk6_pkg::WORD_W-1:0]           cfg_wdata_i
);

  localparam int W  = rk6_pkg::WORD_W;
  localparam int NS = rk6_pkg::STAGES;
  localparam int SW = rk6_pkg::STG_W;
  localparam logic [W-1:0] ONE_FIX = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] DT_RST  = ONE_FIX / W'(400);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ISSUE  = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  typedef enum logic [4:0] {
    PH_A   = 5'b00001,
    PH_DT  = 5'b00010,
    PH_LAM = 5'b00100,
    PH_B   = 5'b01000,
    PH_Z   = 5'b10000
  } phase_e;

  logic [W-1:0] a_tab [NS*NS];
  logic [W-1:0] b_tab [NS];

  for (genvar g = 0; g < NS*NS; g++) begin : g_a_coef
    localparam logic [W-1:0] COEF =
      rk6_pkg::frac_to_fixed(rk6_pkg::A_NUM[g], rk6_pkg::A_DEN[g], FRAC_BITS);
    assign a_tab[g] = COEF;
  end

  for (genvar g = 0; g < NS; g++) begin : g_b_coef
    localparam logic [W-1:0] COEF =
      rk6_pkg::frac_to_fixed(rk6_pkg::B_NUM[g], rk6_pkg::B_DEN[g], FRAC_BITS);
    assign b_tab[g] = COEF;
  end

  state_e       state_q, state_d;
  phase_e       phase_q, phase_d;
  logic [SW-1:0] s_q, s_d;
  logic [SW-1:0] j_q, j_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] z_q, z_d;
  logic         sat_q, sat_d;
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_z_q, out_z_d;
  logic         out_sat_q, out_sat_d;
  logic [W-1:0] lambda_q;
  logic [W-1:0] dt_q;
  logic [W-1:0] init_q;
  logic [W-1:0] k_q [NS];
  logic         k_we;

  logic              mul_start;
  logic [W-1:0]      mul_x;
  logic [W-1:0]      mul_y;
  logic              mul_done;
  rk6_pkg::mul_res_t mul_res;

  logic [SW-1:0] k_idx;
  logic [W-1:0]  add_base;
  logic [W-1:0]  add_sum;
  logic          add_over;
  logic [W-1:0]  add_val;
  logic          in_accept;
  logic          out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign k_idx = (phase_q == PH_A) ? j_q : s_q;

  always_comb begin
    unique case (phase_q)
      PH_A: begin
        mul_x = a_tab[{s_q, j_q}];
        mul_y = k_q[k_idx];
      end
      PH_B: begin
        mul_x = b_tab[s_q];
        mul_y = k_q[k_idx];
      end
      PH_LAM: begin
        mul_x = lambda_q;
        mul_y = acc_q;
      end
      PH_DT, PH_Z: begin
        mul_x = dt_q;
        mul_y = acc_q;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_start = (state_q == ST_ISSUE);

  rk6_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // saturating add of the product onto the running sum or onto z
  assign add_base = (phase_q == PH_A || phase_q == PH_B) ? acc_q : z_q;
  assign add_sum  = add_base + mul_res.value;
  assign add_over = (add_base[W-1] == mul_res.value[W-1]) &&
                    (add_sum[W-1] != add_base[W-1]);
  assign add_val  = add_over ? (add_base[W-1] ? rk6_pkg::SAT_MIN : rk6_pkg::SAT_MAX)
                             : add_sum;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    s_d         = s_q;
    j_d         = j_q;
    acc_d       = acc_q;
    z_d         = z_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_z_d     = out_z_q;
    out_sat_d   = out_sat_q;
    k_we        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (restart_i) begin
            z_d         = init_q;
            out_valid_d = 1'b1;
            out_z_d     = init_q;
            out_sat_d   = 1'b0;
          end else begin
            s_d     = '0;
            j_d     = '0;
            phase_d = PH_DT;
            acc_d   = '0;
            sat_d   = 1'b0;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_ISSUE;
        unique case (phase_q)
          PH_A: begin
            acc_d = add_val;
            sat_d = sat_q | mul_res.sat | add_over;
            if (j_q == SW'(s_q - SW'(1))) begin
              phase_d = PH_DT;
            end else begin
              j_d = j_q + SW'(1);
            end
          end
          PH_DT: begin
            acc_d   = add_val;
            sat_d   = sat_q | mul_res.sat | add_over;
            phase_d = PH_LAM;
          end
          PH_LAM: begin
            k_we  = 1'b1;
            acc_d = '0;
            sat_d = sat_q | mul_res.sat;
            if (s_q == SW'(NS - 1)) begin
              s_d     = '0;
              phase_d = PH_B;
            end else begin
              s_d     = s_q + SW'(1);
              j_d     = '0;
              phase_d = PH_A;
            end
          end
          PH_B: begin
            acc_d = add_val;
            sat_d = sat_q | mul_res.sat | add_over;
            if (s_q == SW'(NS - 1)) begin
              phase_d = PH_Z;
            end else begin
              s_d = s_q + SW'(1);
            end
          end
          PH_Z: begin
            z_d     = add_val;
            sat_d   = sat_q | mul_res.sat | add_over;
            state_d = ST_FINISH;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_z_d     = z_q;
          out_sat_d   = sat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_DT;
      s_q         <= '0;
      j_q         <= '0;
      acc_q       <= '0;
      z_q         <= ONE_FIX;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      s_q         <= s_d;
      j_q         <= j_d;
      acc_q       <= acc_d;
      z_q         <= z_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_z_q   <= out_z_d;
    out_sat_q <= out_sat_d;
    if (k_we) begin
      k_q[s_q] <= mul_res.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= ONE_FIX;
      dt_q     <= DT_RST;
      init_q   <= ONE_FIX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rk6_pkg::CFG_RATE_LAMBDA:   lambda_q <= cfg_wdata_i;
        rk6_pkg::CFG_STEP_SIZE:     dt_q     <= cfg_wdata_i;
        rk6_pkg::CFG_INITIAL_VALUE: init_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign z_value_o   = out_z_q;
  assign saturated_o = out_sat_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_WAIT)
    else $error("multiplier result arrived outside the wait state");

  a_issue_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ISSUE |=> state_q == ST_WAIT)
    else $error("issue not followed by wait");

  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !restart_i) |=> (state_q == ST_ISSUE && phase_q == PH_DT && acc_q == '0))
    else $error("step item did not start at the first stage");

  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && restart_i) |=> (out_valid_o && !saturated_o && z_value_o == z_q))
    else $error("restart item did not present the reloaded value");

endmodule

>>> tb/sv/rk6_step_checker.sv
module rk6_step_checker #(
  parameter int FRAC_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              restart_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [rk6_pkg::WORD_W-1:0] z_value_i,
  input  logic                              saturated_i,
  input  logic                              cfg_we_i,
  input  logic [rk6_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rk6_pkg::WORD_W-1:0]        cfg_wdata_i,
  input  logic                              drained_i,
  output int                                mismatches_o,
  output int                                pending_o,
  output int                                results_o,
  output int                                sat_results_o
);

  localparam int WW = rk6_pkg::WORD_W;
  localparam int NS = rk6_pkg::STAGES;

  typedef struct packed {
    logic signed [WW-1:0] z;
    logic                 sat;
  } z_result_t;

  z_result_t z_pending [$];
  z_result_t fresh;
  z_result_t want;

  logic signed [WW-1:0] a_coef [NS][NS];
  logic signed [WW-1:0] b_coef [NS];
  logic signed [WW-1:0] slope [NS];
  logic signed [WW-1:0] lambda_r;
  logic signed [WW-1:0] dt_r;
  logic signed [WW-1:0] z_init_r;
  logic signed [WW-1:0] z_now;
  logic signed [WW-1:0] acc;
  logic signed [WW-1:0] stage_val;
  logic signed [WW-1:0] slope_sum;
  logic                 sat_hit;
  logic                 drain_checked = 1'b0;
  int                   mismatches = 0;
  int                   results = 0;
  int                   sat_results = 0;

  // tableau fraction in fixed point, nearest, ties up in magnitude
  function automatic logic signed [WW-1:0] coef(input int num, input int den);
    logic [2*WW-1:0] mag;
    mag = (2*WW)'(num < 0 ? -num : num);
    mag = ((mag << (FRAC_BITS + 1)) + (2*WW)'(den)) / ((2*WW)'(den) << 1);
    return (num < 0) ? -mag[WW-1:0] : mag[WW-1:0];
  endfunction

  function automatic logic signed [WW-1:0] fx_add(input logic signed [WW-1:0] x,
                                                  input logic signed [WW-1:0] y);
    logic signed [WW-1:0] r;
    r = x + y;
    if (x[WW-1] == y[WW-1] && r[WW-1] != x[WW-1]) begin
      sat_hit = 1'b1;
      return x[WW-1] ? rk6_pkg::SAT_MIN : rk6_pkg::SAT_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [WW-1:0] fx_mul(input logic signed [WW-1:0] x,
                                                  input logic signed [WW-1:0] y);
    logic            neg;
    logic [WW-1:0]   mx;
    logic [WW-1:0]   my;
    logic [2*WW-1:0] prod;
    logic [2*WW-1:0] lim;
    neg  = x[WW-1] ^ y[WW-1];
    mx   = x[WW-1] ? -x : x;
    my   = y[WW-1] ? -y : y;
    prod = {{WW{1'b0}}, mx} * {{WW{1'b0}}, my};
    prod = (prod + ((2*WW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim  = neg ? (2*WW)'(rk6_pkg::SAT_MIN) : (2*WW)'(rk6_pkg::SAT_MAX);
    if (prod > lim) begin
      sat_hit = 1'b1;
      return neg ? rk6_pkg::SAT_MIN : rk6_pkg::SAT_MAX;
    end
    return neg ? -prod[WW-1:0] : prod[WW-1:0];
  endfunction

  task automatic flag_error(input string what);
    if (mismatches < 40) begin
      $display("ERROR %0t: %s", $time, what);
    end
    mismatches++;
  endtask

  initial begin
    for (int s = 0; s < NS; s++) begin
      b_coef[s] = '0;
      for (int j = 0; j < NS; j++) begin
        a_coef[s][j] = '0;
      end
    end
    a_coef[1][0] = coef(1, 6);
    a_coef[2][0] = coef(1, 12);
    a_coef[2][1] = coef(1, 12);
    a_coef[3][1] = coef(-4, 33);
    a_coef[3][2] = coef(5, 11);
    // row 4 uses -29/44 so that it sums to one half
    a_coef[4][0] = coef(-1, 4);
    a_coef[4][1] = coef(-29, 44);
    a_coef[4][2] = coef(31, 22);
    a_coef[5][0] = coef(3, 11);
    a_coef[5][1] = coef(8, 33);
    a_coef[5][2] = coef(-4, 11);
    a_coef[5][3] = coef(1, 11);
    a_coef[5][4] = coef(14, 33);
    a_coef[6][0] = coef(-17, 48);
    a_coef[6][1] = coef(-5, 12);
    a_coef[6][2] = coef(1, 1);
    a_coef[6][3] = coef(1, 1);
    a_coef[6][4] = coef(-13, 12);
    a_coef[6][5] = coef(11, 16);
    a_coef[7][0] = coef(20, 39);
    a_coef[7][1] = coef(12, 39);
    a_coef[7][2] = coef(-31, 39);
    a_coef[7][3] = coef(-1, 39);
    a_coef[7][4] = coef(34, 39);
    a_coef[7][5] = coef(-11, 39);
    a_coef[7][6] = coef(16, 39);
    b_coef[0] = coef(13, 200);
    b_coef[2] = coef(4, 25);
    b_coef[3] = coef(11, 40);
    b_coef[5] = coef(11, 40);
    b_coef[6] = coef(4, 25);
    b_coef[7] = coef(13, 200);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_r = WW'(1) << FRAC_BITS;
      dt_r     = (WW'(1) << FRAC_BITS) / 400;
      z_init_r = WW'(1) << FRAC_BITS;
      z_now    = z_init_r;
      for (int s = 0; s < NS; s++) begin
        slope[s] = '0;
      end
      z_pending.delete();
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rk6_pkg::CFG_RATE_LAMBDA:   lambda_r = cfg_wdata_i;
          rk6_pkg::CFG_STEP_SIZE:     dt_r = cfg_wdata_i;
          rk6_pkg::CFG_INITIAL_VALUE: z_init_r = cfg_wdata_i;
          default: ;
        endcase
      end

      // results first, so a result in the same cycle as an item cannot hide behind it
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (saturated_i === 1'b1) begin
          sat_results++;
        end
        if (z_pending.size() == 0) begin
          flag_error($sformatf("result z=%h sat=%b with nothing pending",
                               z_value_i, saturated_i));
        end else begin
          want = z_pending.pop_front();
          if (z_value_i !== want.z) begin
            flag_error($sformatf("result %0d: z=%h, predicted %h", results, z_value_i, want.z));
          end
          if (saturated_i !== want.sat) begin
            flag_error($sformatf("result %0d: saturated=%b, predicted %b",
                                 results, saturated_i, want.sat));
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        sat_hit = 1'b0;
        if (restart_i) begin
          z_now = z_init_r;
        end else begin
          for (int s = 0; s < NS; s++) begin
            acc = '0;
            for (int j = 0; j < s; j++) begin
              acc = fx_add(acc, fx_mul(a_coef[s][j], slope[j]));
            end
            stage_val = fx_add(z_now, fx_mul(dt_r, acc));
            slope[s]  = fx_mul(lambda_r, stage_val);
          end
          slope_sum = '0;
          for (int s = 0; s < NS; s++) begin
            slope_sum = fx_add(slope_sum, fx_mul(b_coef[s], slope[s]));
          end
          z_now = fx_add(z_now, fx_mul(dt_r, slope_sum));
        end
        fresh.z   = z_now;
        fresh.sat = sat_hit;
        z_pending.push_back(fresh);
      end

      if (drained_i && !drain_checked) begin
        drain_checked = 1'b1;
        if (z_pending.size() != 0) begin
          flag_error($sformatf("%0d predicted results never came out", z_pending.size()));
        end
      end
    end
    mismatches_o  <= mismatches;
    pending_o     <= z_pending.size();
    results_o     <= results;
    sat_results_o <= sat_results;
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;

  localparam int FRAC_BITS   = 48;
  localparam int ITEM_TARGET = 1250;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_WAIT  = 500;
  localparam int WW          = rk6_pkg::WORD_W;
  localparam int IW          = rk6_pkg::CFG_IDX_W;

  localparam logic [IW-1:0] CFG_UNUSED = 2'd3;
  localparam logic [WW-1:0] ONE        = WW'(1) << FRAC_BITS;
  localparam logic [WW-1:0] NEG_ONE    = -ONE;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 restart_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [WW-1:0] z_value_o;
  logic                 saturated_o;
  logic                 cfg_we_i    = 1'b0;
  logic [IW-1:0]        cfg_idx_i   = '0;
  logic [WW-1:0]        cfg_wdata_i = '0;
  logic                 drained     = 1'b0;

  int mismatches;
  int pending;
  int results;
  int sat_results;
  int items_sent    = 0;
  int steps_sent    = 0;
  int restarts_sent = 0;
  int cfg_writes    = 0;
  int cycles        = 0;
  int hold_left     = 0;
  bit hold_used     = 1'b0;

  always #5 clk_i = ~clk_i;

  rk6_linear_ode_step_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .z_value_o  (z_value_o),
    .saturated_o(saturated_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  rk6_step_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .z_value_i    (z_value_o),
    .saturated_i  (saturated_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .drained_i    (drained),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .sat_results_o(sat_results)
  );

  function automatic bit in_quiet_stretch();
    return items_sent >= 400 && items_sent < 560;
  endfunction

  // mostly moderate values, now and then an extreme or a raw pattern
  function automatic logic [WW-1:0] pick_setting(input logic [IW-1:0] idx);
    logic [WW-1:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 3) begin
      unique case ($urandom_range(0, 5))
        0:       return rk6_pkg::SAT_MIN;
        1:       return rk6_pkg::SAT_MAX;
        2:       return '0;
        3:       return WW'(1);
        4:       return '1;
        default: return raw;
      endcase
    end
    unique case (idx)
      rk6_pkg::CFG_RATE_LAMBDA: return WW'($signed(raw) >>> 13);
      rk6_pkg::CFG_STEP_SIZE:   return ($urandom_range(0, 3) == 0) ? -(raw >> 18) : (raw >> 18);
      default:                  return WW'($signed(raw) >>> 8);
    endcase
  endfunction

  task automatic send_item(input logic rs);
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
    if (rs) begin
      restarts_sent++;
    end else begin
      steps_sent++;
    end
  endtask

  task automatic maybe_pause();
    int gap;
    if (in_quiet_stretch() || $urandom_range(0, 99) >= 9) begin
      return;
    end
    // long gaps let the next item arrive at any point of a step
    gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 450);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [IW-1:0] idx, input logic [WW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  task automatic apply_settings(input logic [WW-1:0] lam, input logic [WW-1:0] dt,
                                input logic [WW-1:0] z0, input bit poke_unused);
    cfg_write(rk6_pkg::CFG_RATE_LAMBDA, lam);
    cfg_write(rk6_pkg::CFG_STEP_SIZE, dt);
    cfg_write(rk6_pkg::CFG_INITIAL_VALUE, z0);
    if (poke_unused) begin
      cfg_write(CFG_UNUSED, {$urandom, $urandom});
    end
    cfg_we_i <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off, and a stretch with none
  always @(posedge clk_i) begin
    if (!hold_used && items_sent >= 60) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (in_quiet_stretch()) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 9);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase_len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: steps from z = 1.0, then a restart
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    drain_results();

    // zero step size holds z, here at the top of the range
    apply_settings(NEG_ONE, '0, rk6_pkg::SAT_MAX, 1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    drain_results();

    apply_settings(rk6_pkg::SAT_MAX, rk6_pkg::SAT_MAX, rk6_pkg::SAT_MIN, 1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    drain_results();

    apply_settings(rk6_pkg::SAT_MIN, rk6_pkg::SAT_MIN, WW'(1), 1'b0);
    send_item(1'b1);
    send_item(1'b0);
    drain_results();

    // negative step, and a write to the unused index that must change nothing
    apply_settings(ONE << 1, -(ONE / 400), -((ONE << 1) + ONE + (ONE >> 1)), 1'b1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    drain_results();

    // new initial value only shows after the next restart
    cfg_write(rk6_pkg::CFG_INITIAL_VALUE, ONE * 5);
    cfg_we_i <= 1'b0;
    send_item(1'b0);
    send_item(1'b1);

    while (items_sent < ITEM_TARGET) begin
      drain_results();
      apply_settings(pick_setting(rk6_pkg::CFG_RATE_LAMBDA),
                     pick_setting(rk6_pkg::CFG_STEP_SIZE),
                     pick_setting(rk6_pkg::CFG_INITIAL_VALUE), $urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 150);
      for (int n = 0; n < phase_len && items_sent < ITEM_TARGET; n++) begin
        if (n > 0) begin
          maybe_pause();
        end
        send_item(n == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 7) == 0));
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    drained <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("%0d step items and %0d restart items across %0d register writes",
             steps_sent, restarts_sent, cfg_writes);
    $display("%0d results checked, %0d flagged saturated, %0d mismatches",
             results, sat_results, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
